FILE: hw/rtl/ccsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccsm_pkg
// Shared types and character constants for the comment stripper and minifier.
// ----------------------------------------------------------------------------
package ccsm_pkg;

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       out_last;
   } rsp_type;

   // classified transaction handed from the front end to the back end
   typedef struct packed {
      logic       pre_slash;
      logic       has_char;
      logic [7:0] chr;
      logic       last;
   } entry_type;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_LINE   = 2'd1,
      MODE_BLOCK  = 2'd2
   } mode_type;

endpackage

FILE: hw/rtl/c_comment_strip_whitespace_minify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_comment_strip_whitespace_minify
// Strips C-style comments from a text byte stream and minifies whitespace.
// ----------------------------------------------------------------------------
// The front end takes one byte per cycle, strips // and /* */ comments and
// queues a classified transaction in a QUEUE_DEPTH-entry queue; it takes no
// byte while the queue is full. The back end gives at most one result per
// cycle into an output register while the queue holds an entry and the
// output is free: a held slash comes out before the byte that released it;
// a visible byte comes after its held newlines (at most NEWLINE_RUN_MAX),
// so the back-end sequencer sets the sustained rate while the queue lets the
// front keep accepting. Every text ends with one result carrying out_last, a
// bare end marker (out_valid low) when the final byte gives nothing.
module c_comment_strip_whitespace_minify import ccsm_pkg::*; #(
   parameter int NEWLINE_RUN_MAX = 16,
   parameter int QUEUE_DEPTH     = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   entry_type front_entry, head_entry;
   logic      accept, full, head_valid, pop;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   ccsm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .entry    (front_entry)
   );

   ccsm_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (front_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_entry)
   );

   ccsm_back #(
      .NEWLINE_RUN_MAX (NEWLINE_RUN_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: hw/rtl/ccsm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccsm_front
// Comment stripper: tracks comment state and classifies each input byte.
// ----------------------------------------------------------------------------
module ccsm_front import ccsm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  req_type   req_data,
   output entry_type entry
);

   mode_type mode_ff, mode_in;
   logic     slash_held_ff, slash_held_in;
   logic     star_seen_ff, star_seen_in;
   logic [7:0] c;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_NORMAL;
         slash_held_ff <= 1'b0;
         star_seen_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         slash_held_ff <= slash_held_in;
         star_seen_ff  <= star_seen_in;
      end
   end

   always_comb begin
      c             = req_data.in_byte;
      mode_in       = mode_ff;
      slash_held_in = slash_held_ff;
      star_seen_in  = star_seen_ff;
      entry.pre_slash = 1'b0;
      entry.has_char  = 1'b0;
      entry.chr       = c;
      entry.last      = req_data.in_last;
      case (mode_ff)
         MODE_LINE: begin
            if (c == CH_NL) begin
               mode_in        = MODE_NORMAL;
               entry.has_char = 1'b1;
            end
         end
         MODE_BLOCK: begin
            if (star_seen_ff && c == CH_SLASH) begin
               mode_in      = MODE_NORMAL;
               star_seen_in = 1'b0;
            end else begin
               star_seen_in = (c == CH_STAR);
            end
         end
         default: begin
            if (slash_held_ff) begin
               slash_held_in = 1'b0;
               if (c == CH_SLASH) begin
                  mode_in = MODE_LINE;
               end else if (c == CH_STAR) begin
                  mode_in      = MODE_BLOCK;
                  star_seen_in = 1'b0;
               end else begin
                  entry.pre_slash = 1'b1;
                  entry.has_char  = 1'b1;
               end
            end else if (c == CH_SLASH) begin
               if (req_data.in_last) begin
                  entry.has_char = 1'b1;
               end else begin
                  slash_held_in = 1'b1;
               end
            end else begin
               entry.has_char = 1'b1;
            end
         end
      endcase
      // end of text returns to reset
      if (req_data.in_last) begin
         mode_in       = MODE_NORMAL;
         slash_held_in = 1'b0;
         star_seen_in  = 1'b0;
      end
   end

endmodule

FILE: hw/rtl/ccsm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccsm_fifo
// Short queue of classified transactions between front and back end.
// ----------------------------------------------------------------------------
module ccsm_fifo import ccsm_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: hw/rtl/ccsm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccsm_back
// Whitespace minifier: releases held newlines and spaces, at most one result a cycle when not stalled.
// ----------------------------------------------------------------------------
module ccsm_back import ccsm_pkg::*; #(
   parameter int NEWLINE_RUN_MAX = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  entry_type head_data,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   localparam int NL_W = $clog2(NEWLINE_RUN_MAX + 1);

   logic            started_ff, started_in;
   logic            space_ff, space_in;
   logic [NL_W-1:0] nl_ff, nl_in;
   logic            step_ff, step_in;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff;

   logic       out_free, go, emit;
   rsp_type    emit_data;
   logic       feed_is_slash, feed_valid, final_feed, is_nl, is_sp, chr_is_ws;
   logic [7:0] feed;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign go        = head_valid && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      feed_is_slash = head_data.pre_slash && !step_ff;
      feed_valid    = feed_is_slash || head_data.has_char;
      feed          = feed_is_slash ? CH_SLASH : head_data.chr;
      chr_is_ws     = (head_data.chr == CH_NL) || (head_data.chr == CH_SP) ||
                      (head_data.chr == CH_TAB);
      // a released slash is the text's last result when the byte after it is a blank that ends the text
      final_feed    = !feed_is_slash || !head_data.has_char ||
                      (head_data.last && chr_is_ws);
      is_nl         = (feed == CH_NL);
      is_sp         = (feed == CH_SP) || (feed == CH_TAB);
      started_in    = started_ff;
      space_in      = space_ff;
      nl_in         = nl_ff;
      step_in       = step_ff;
      pop           = 1'b0;
      emit          = 1'b0;
      emit_data.out_byte  = feed;
      emit_data.out_valid = 1'b1;
      emit_data.out_last  = 1'b0;
      if (go) begin
         if (!feed_valid || is_nl || is_sp) begin
            if (feed_valid && is_nl) begin
               if (started_ff && nl_ff < NL_W'(NEWLINE_RUN_MAX)) begin
                  nl_in = nl_ff + 1'b1;
               end
               space_in = 1'b0;
            end else if (feed_valid && is_sp) begin
               if (started_ff && nl_ff == '0) begin
                  space_in = 1'b1;
               end
            end
            pop     = 1'b1;
            step_in = 1'b0;
            if (head_data.last) begin
               // bare end marker when the text's last byte gave nothing
               if (!head_data.pre_slash) begin
                  emit                = 1'b1;
                  emit_data.out_byte  = '0;
                  emit_data.out_valid = 1'b0;
                  emit_data.out_last  = 1'b1;
               end
               started_in = 1'b0;
               space_in   = 1'b0;
               nl_in      = '0;
            end
         end else begin
            emit = 1'b1;
            if (started_ff && nl_ff != '0) begin
               emit_data.out_byte = CH_NL;
               nl_in              = nl_ff - 1'b1;
            end else if (started_ff && space_ff) begin
               emit_data.out_byte = CH_SP;
               space_in           = 1'b0;
            end else begin
               emit_data.out_last = head_data.last && final_feed;
               started_in         = 1'b1;
               if (final_feed) begin
                  pop     = 1'b1;
                  step_in = 1'b0;
                  if (head_data.last) begin
                     started_in = 1'b0;
                     space_in   = 1'b0;
                     nl_in      = '0;
                  end
               end else begin
                  step_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         space_ff     <= 1'b0;
         nl_ff        <= '0;
         step_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         started_ff <= started_in;
         space_ff   <= space_in;
         nl_ff      <= nl_in;
         step_ff    <= step_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= emit_data;
      end
   end

endmodule

FILE: bench/minify_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minify_checker
// Watches both channels of the comment stripper and minifier, predicts the
// minified text of every accepted source byte and compares each result
// transaction, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module minify_checker import ccsm_pkg::*; #(
   parameter int NEWLINE_RUN_MAX = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      awaited
);

   rsp_type    expected_text[$];
   rsp_type    want;
   mode_type   strip_mode;
   logic       slash_waiting;
   logic       star_before;
   logic       seen_text;
   logic       space_held;
   logic [4:0] held_newlines;

   initial begin
      mismatches = 0;
      awaited    = 0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic clear_text_state();
      strip_mode    = MODE_NORMAL;
      slash_waiting = 1'b0;
      star_before   = 1'b0;
      seen_text     = 1'b0;
      space_held    = 1'b0;
      held_newlines = '0;
   endtask

   task automatic put_char(input logic [7:0] c);
      expected_text.push_back('{out_byte: c, out_valid: 1'b1, out_last: 1'b0});
   endtask

   task automatic minify_char(input logic [7:0] c);
      if (c == CH_NL) begin
         if (seen_text && held_newlines < NEWLINE_RUN_MAX) held_newlines++;
         space_held = 1'b0;
      end else if (c == CH_SP || c == CH_TAB) begin
         if (seen_text && held_newlines == 0) space_held = 1'b1;
      end else begin
         if (seen_text) begin
            if (held_newlines > 0) repeat (held_newlines) put_char(CH_NL);
            else if (space_held) put_char(CH_SP);
         end
         put_char(c);
         seen_text     = 1'b1;
         held_newlines = '0;
         space_held    = 1'b0;
      end
   endtask

   task automatic strip_char(input logic [7:0] c, input logic is_last);
      case (strip_mode)
         MODE_LINE: begin
            if (c == CH_NL) begin
               strip_mode = MODE_NORMAL;
               minify_char(CH_NL);
            end
         end
         MODE_BLOCK: begin
            if (star_before && c == CH_SLASH) begin
               strip_mode  = MODE_NORMAL;
               star_before = 1'b0;
            end else begin
               star_before = (c == CH_STAR);
            end
         end
         default: begin
            if (slash_waiting) begin
               slash_waiting = 1'b0;
               if (c == CH_SLASH) begin
                  strip_mode = MODE_LINE;
               end else if (c == CH_STAR) begin
                  strip_mode  = MODE_BLOCK;
                  star_before = 1'b0;
               end else begin
                  minify_char(CH_SLASH);
                  minify_char(c);
               end
            end else if (c == CH_SLASH) begin
               if (is_last) minify_char(CH_SLASH);
               else slash_waiting = 1'b1;
            end else begin
               minify_char(c);
            end
         end
      endcase
   endtask

   task automatic predict_text(input req_type item);
      int      before_count;
      rsp_type tail;
      before_count = expected_text.size();
      strip_char(item.in_byte, item.in_last);
      if (item.in_last) begin
         if (expected_text.size() == before_count) begin
            expected_text.push_back('{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b1});
         end else begin
            tail = expected_text.pop_back();
            tail.out_last = 1'b1;
            expected_text.push_back(tail);
         end
         clear_text_state();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_text.delete();
         clear_text_state();
      end else begin
         if (req_valid && req_ready) predict_text(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_text.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction byte %h valid %b last %b",
                                         rsp_data.out_byte, rsp_data.out_valid,
                                         rsp_data.out_last));
            end else begin
               want = expected_text.pop_front();
               if (rsp_data.out_byte != want.out_byte)
                  report_mismatch($sformatf("out_byte %h, expected %h",
                                            rsp_data.out_byte, want.out_byte));
               if (rsp_data.out_valid != want.out_valid)
                  report_mismatch($sformatf("out_valid %b, expected %b",
                                            rsp_data.out_valid, want.out_valid));
               if (rsp_data.out_last != want.out_last)
                  report_mismatch($sformatf("out_last %b, expected %b",
                                            rsp_data.out_last, want.out_last));
            end
         end
      end
      awaited = expected_text.size();
   end

endmodule

FILE: bench/tb_c_comment_strip_whitespace_minify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_c_comment_strip_whitespace_minify
// Feeds the comment stripper and minifier with short directed texts and then
// with random texts built from words, blanks, newline runs and comments, under
// varying idle patterns and back-pressure; a checker beside the block predicts
// and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_c_comment_strip_whitespace_minify;
   import ccsm_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 250;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int         mismatches;
   int         awaited;
   int         send_gap_pct = 0;
   int         recv_gap_pct = 0;
   int         hold_requests = 0;
   int         hold_seen = 0;
   int         hold_left = 0;
   int         sent_items = 0;
   int         idle_cycles = 0;
   logic [7:0] text_q[$];

   always #5 clock = ~clock;

   c_comment_strip_whitespace_minify dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   minify_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .awaited    (awaited)
   );

   // receiver: random stalls, plus a long hold-off when asked
   always @(negedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input logic [7:0] c, input logic is_last);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{in_byte: c, in_last: is_last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent_items++;
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_item(text_q[i], i == text_q.size() - 1);
   endtask

   task automatic load_string(input string s);
      text_q.delete();
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task automatic build_random_text();
      int kind;
      int keep;
      text_q.delete();
      repeat ($urandom_range(12, 1)) begin
         kind = $urandom_range(99);
         if (kind < 30) begin
            repeat ($urandom_range(5, 1)) text_q.push_back(8'h61 + 8'($urandom_range(25)));
         end else if (kind < 44) begin
            repeat ($urandom_range(4, 1)) text_q.push_back($urandom_range(1) ? CH_SP : CH_TAB);
         end else if (kind < 58) begin
            repeat ($urandom_range(3, 1)) text_q.push_back(CH_NL);
         end else if (kind < 63) begin
            repeat ($urandom_range(20, 15)) text_q.push_back(CH_NL);
         end else if (kind < 73) begin
            text_q.push_back(CH_SLASH);
            text_q.push_back(CH_SLASH);
            repeat ($urandom_range(4)) begin
               case ($urandom_range(3))
                  0: text_q.push_back(CH_STAR);
                  1: text_q.push_back(CH_SLASH);
                  2: text_q.push_back(CH_SP);
                  default: text_q.push_back(8'h61 + 8'($urandom_range(25)));
               endcase
            end
            text_q.push_back(CH_NL);
         end else if (kind < 83) begin
            text_q.push_back(CH_SLASH);
            text_q.push_back(CH_STAR);
            repeat ($urandom_range(5)) begin
               case ($urandom_range(4))
                  0: text_q.push_back(CH_STAR);
                  1: text_q.push_back(CH_SLASH);
                  2: text_q.push_back(CH_SP);
                  3: text_q.push_back(CH_NL);
                  default: text_q.push_back(8'h61 + 8'($urandom_range(25)));
               endcase
            end
            text_q.push_back(CH_STAR);
            text_q.push_back(CH_SLASH);
         end else if (kind < 88) begin
            text_q.push_back($urandom_range(1) ? CH_SLASH : CH_STAR);
         end else begin
            text_q.push_back(8'($urandom_range(255)));
         end
      end
      // broken texts: cut short, often inside a comment
      if ($urandom_range(9) == 0) begin
         keep = $urandom_range(text_q.size(), 1);
         while (text_q.size() > keep) void'(text_q.pop_back());
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_gap_pct = 33;
      recv_gap_pct = 67;
      text_q = '{8'h00, 8'hFF};
      send_text();
      load_string(" \t\n");
      send_text();
      load_string("/");
      send_text();
      load_string("a/*/*/b");
      send_text();
      load_string("c//z\nd/");
      send_text();
      load_string("/e\t/*q");
      send_text();

      // long receiver hold-off while the sender keeps offering
      hold_requests++;
      while (sent_items < 100) begin
         build_random_text();
         send_text();
      end

      req_valid <= 1'b0;
      while (awaited != 0) @(negedge clock);

      send_gap_pct = 67;
      recv_gap_pct = 33;
      while (sent_items < 190) begin
         build_random_text();
         send_text();
      end

      send_gap_pct = 0;
      recv_gap_pct = 0;
      while (sent_items < 265) begin
         build_random_text();
         send_text();
      end

      req_valid <= 1'b0;
      while (awaited != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (mismatches == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
